[rtl/core/hhi_pkg.sv]
// ----------------------------------------------------------------------------
// hhi_pkg
// Shared widths, codes and Q24.24 saturating helpers for the Hermite history
// interpolator.
// ----------------------------------------------------------------------------
package hhi_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int NUM_VARS   = 8;
    localparam int NUM_DELAYS = 8;

    localparam int IDX_W  = $clog2(HIST_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int VAR_W  = $clog2(NUM_VARS);
    localparam int DLY_W  = $clog2(NUM_DELAYS);
    localparam int ADDR_W = IDX_W + VAR_W;
    localparam int Q_W    = 48;
    localparam int FRAC_W = 24;
    localparam int HALF_W = Q_W / 2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_LATER = 2'd1,
        ST_NO_PRED  = 2'd2,
        ST_ZERO_SPN = 2'd3
    } status_t;

    // Multiply steps of the Hermite evaluation, in issue order
    typedef enum logic [3:0] {
        MS_LIN_B = 4'd0,
        MS_LIN_N = 4'd1,
        MS_B1    = 4'd2,
        MS_HB    = 4'd3,
        MS_B2    = 4'd4,
        MS_HN    = 4'd5,
        MS_B3    = 4'd6,
        MS_TT    = 4'd7,
        MS_OUT   = 4'd8
    } mstep_t;

    function automatic logic signed [Q_W-1:0] sat_add(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
            return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
            return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    // Magnitude; the most negative value maps to 2^47
    function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] a);
        return a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
    endfunction

    // Apply sign to a wide magnitude with saturation
    function automatic logic signed [Q_W-1:0] qsat(
        input logic [Q_W+FRAC_W:0] m,
        input logic                neg
    );
        if (neg) begin
            if (m > (Q_W+FRAC_W+1)'($unsigned(Q_MIN)))
                return Q_MIN;
            return -$signed(m[Q_W-1:0]);
        end
        if (m > (Q_W+FRAC_W+1)'(Q_MAX))
            return Q_MAX;
        return $signed(m[Q_W-1:0]);
    endfunction

endpackage

[rtl/core/hhi_req_if.sv]
// ----------------------------------------------------------------------------
// hhi_req_if
// Request channel: write, clear-hints or query item with valid/ready.
// ----------------------------------------------------------------------------
interface hhi_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           req_type;
    logic [hhi_pkg::IDX_W-1:0]            entry_index;
    logic [hhi_pkg::VAR_W-1:0]            var_index;
    logic [hhi_pkg::DLY_W-1:0]            delay_index;
    logic signed [hhi_pkg::Q_W-1:0]       sample_time;
    logic signed [hhi_pkg::Q_W-1:0]       sample_value;
    logic signed [hhi_pkg::Q_W-1:0]       sample_slope;

    modport source (
        output valid, req_type, entry_index, var_index, delay_index,
               sample_time, sample_value, sample_slope,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, var_index, delay_index,
               sample_time, sample_value, sample_slope,
        output ready
    );
endinterface

[rtl/core/hhi_rsp_if.sv]
// ----------------------------------------------------------------------------
// hhi_rsp_if
// Response channel: interpolated value, status and upper index.
// ----------------------------------------------------------------------------
interface hhi_rsp_if;
    logic                            valid;
    logic                            ready;
    logic signed [hhi_pkg::Q_W-1:0]  interp_value;
    logic [1:0]                      status;
    logic [hhi_pkg::IDX_W-1:0]       upper_index;

    modport source (
        output valid, interp_value, status, upper_index,
        input  ready
    );

    modport sink (
        input  valid, interp_value, status, upper_index,
        output ready
    );
endinterface

[rtl/core/hermite_history_interpolator.sv]
// ----------------------------------------------------------------------------
// hermite_history_interpolator
// History table of time points with value and slope per variable; answers
// delayed-value queries by cubic Hermite interpolation in Q24.24.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_type, entry_index, var_index, delay_index,
//          |     | sample_time, sample_value, sample_slope
//  rsp     | out | interp_value, status, upper_index
//
//  Write, clear and unused codes go straight to the result handoff. A query
//  scans entries from the delay's hint, fetches and checks the bracket, runs
//  the bit-serial divider, forms th and prepares, then computes 9 products on
//  one 24x24 multiplier, then hands the result off before the next accept.
//  req.ready is high only while the sequencer idles; a finished item may
//  still wait in the rsp register. Memories need no clearing pass after
//  reset; only hints, fill count and control state reset.
// ----------------------------------------------------------------------------
module hermite_history_interpolator (
    input  logic         clk,
    input  logic         rst_n,
    hhi_req_if.sink      req,
    hhi_rsp_if.source    rsp
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SCAN = 13'b0000000000010,
        S_SCMP = 13'b0000000000100,
        S_F0   = 13'b0000000001000,
        S_F1   = 13'b0000000010000,
        S_F2   = 13'b0000000100000,
        S_CHK  = 13'b0000001000000,
        S_DIV  = 13'b0000010000000,
        S_DFIN = 13'b0000100000000,
        S_PREP = 13'b0001000000000,
        S_MLD  = 13'b0010000000000,
        S_MPP  = 13'b0100000000000,
        S_MFIN = 13'b1000000000000
    } state_t;

    localparam int DVD_W = hhi_pkg::Q_W + hhi_pkg::FRAC_W;
    localparam int DCNT_W = $clog2(DVD_W);
    localparam int ACC_W = 2 * hhi_pkg::Q_W;

    state_t state_reg, state_next;
    logic   done_reg;

    // Item context
    logic signed [hhi_pkg::Q_W-1:0]  t_reg;
    logic [hhi_pkg::VAR_W-1:0]       var_reg;
    logic [hhi_pkg::DLY_W-1:0]       dly_reg;
    logic [hhi_pkg::CNT_W-1:0]       idx_reg;
    logic [hhi_pkg::CNT_W-1:0]       filled_reg;
    logic [hhi_pkg::IDX_W-1:0]       hint_reg [hhi_pkg::NUM_DELAYS];

    // Result staging and output register
    logic signed [hhi_pkg::Q_W-1:0]  res_val_reg;
    logic [1:0]                      res_status_reg;
    logic [hhi_pkg::IDX_W-1:0]       res_upper_reg;
    logic                            out_valid_reg;
    logic signed [hhi_pkg::Q_W-1:0]  out_val_reg;
    logic [1:0]                      out_status_reg;
    logic [hhi_pkg::IDX_W-1:0]       out_upper_reg;

    // Bracket operands
    logic signed [hhi_pkg::Q_W-1:0]  tn_reg, tb_reg, xb_reg, xn_reg, db_reg, dn_reg;
    logic signed [hhi_pkg::Q_W-1:0]  h_reg, th_reg, thm1_reg, oneth_reg, b1a_reg, dx_reg;

    // Divider
    logic [DVD_W-1:0]                div_dvd_reg;
    logic [hhi_pkg::Q_W:0]           div_rem_reg;
    logic [hhi_pkg::Q_W-1:0]         div_den_reg;
    logic [hhi_pkg::Q_W-1:0]         div_q_reg;
    logic                            div_ovf_reg;
    logic                            div_neg_reg;
    logic [DCNT_W-1:0]               div_cnt_reg;

    // Multiplier
    hhi_pkg::mstep_t                 step_reg;
    logic [1:0]                      mk_reg;
    logic [hhi_pkg::Q_W-1:0]         ua_reg, ub_reg;
    logic                            mneg_reg;
    logic [ACC_W-1:0]                acc_reg;
    logic signed [hhi_pkg::Q_W-1:0]  lin_reg, inn_reg, tmp_reg;

    // Memories
    logic signed [hhi_pkg::Q_W-1:0]  tm_mem [hhi_pkg::HIST_DEPTH];
    logic signed [hhi_pkg::Q_W-1:0]  val_mem [hhi_pkg::HIST_DEPTH * hhi_pkg::NUM_VARS];
    logic signed [hhi_pkg::Q_W-1:0]  slp_mem [hhi_pkg::HIST_DEPTH * hhi_pkg::NUM_VARS];
    logic signed [hhi_pkg::Q_W-1:0]  tm_rd_reg, val_rd_reg, slp_rd_reg;
    logic [hhi_pkg::IDX_W-1:0]       tm_addr;
    logic [hhi_pkg::ADDR_W-1:0]      vs_addr;
    logic [hhi_pkg::IDX_W-1:0]       lo_idx;

    logic                            req_acc, wr_en, out_load;
    logic [hhi_pkg::Q_W:0]           rem_sh;
    logic                            rem_ge;
    logic signed [hhi_pkg::Q_W-1:0]  opa, opb, prod, th_new;
    logic [2*hhi_pkg::HALF_W-1:0]    pp;
    logic [ACC_W:0]                  rsum;

    assign req.ready = (state_reg == S_IDLE) && !done_reg;
    assign req_acc   = req.valid && req.ready;
    assign wr_en     = req_acc && (req.req_type == hhi_pkg::REQ_WRITE);
    assign out_load  = done_reg && (!out_valid_reg || rsp.ready);
    assign lo_idx    = idx_reg[hhi_pkg::IDX_W-1:0] - hhi_pkg::IDX_W'(1);

    assign rsp.valid        = out_valid_reg;
    assign rsp.interp_value = out_val_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.upper_index  = out_upper_reg;

    // Memory read addresses
    always_comb
    begin
        tm_addr = idx_reg[hhi_pkg::IDX_W-1:0];
        vs_addr = {idx_reg[hhi_pkg::IDX_W-1:0], var_reg};
        if (state_reg == S_F0)
        begin
            tm_addr = lo_idx;
            vs_addr = {lo_idx, var_reg};
        end
    end

    // History memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tm_mem[req.entry_index] <= req.sample_time;
            val_mem[{req.entry_index, req.var_index}] <= req.sample_value;
            slp_mem[{req.entry_index, req.var_index}] <= req.sample_slope;
        end
        tm_rd_reg  <= tm_mem[tm_addr];
        val_rd_reg <= val_mem[vs_addr];
        slp_rd_reg <= slp_mem[vs_addr];
    end

    // Divider step
    assign rem_sh = {div_rem_reg[hhi_pkg::Q_W-1:0], div_dvd_reg[DVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, div_den_reg};
    assign th_new = hhi_pkg::qsat({hhi_pkg::FRAC_W'(0), div_ovf_reg, div_q_reg}, div_neg_reg);

    // Multiply operand select
    always_comb
    begin
        unique case (step_reg)
            hhi_pkg::MS_LIN_B: begin opa = oneth_reg; opb = xb_reg;   end
            hhi_pkg::MS_LIN_N: begin opa = th_reg;    opb = xn_reg;   end
            hhi_pkg::MS_B1:    begin opa = b1a_reg;   opb = dx_reg;   end
            hhi_pkg::MS_HB:    begin opa = thm1_reg;  opb = h_reg;    end
            hhi_pkg::MS_B2:    begin opa = tmp_reg;   opb = db_reg;   end
            hhi_pkg::MS_HN:    begin opa = th_reg;    opb = h_reg;    end
            hhi_pkg::MS_B3:    begin opa = tmp_reg;   opb = dn_reg;   end
            hhi_pkg::MS_TT:    begin opa = th_reg;    opb = thm1_reg; end
            hhi_pkg::MS_OUT:   begin opa = tmp_reg;   opb = inn_reg;  end
            default:           begin opa = '0;        opb = '0;       end
        endcase
    end

    // Shared 24x24 partial product and rounding
    assign pp = (mk_reg[1] ? ua_reg[hhi_pkg::Q_W-1:hhi_pkg::HALF_W]
                           : ua_reg[hhi_pkg::HALF_W-1:0])
              * (mk_reg[0] ? ub_reg[hhi_pkg::Q_W-1:hhi_pkg::HALF_W]
                           : ub_reg[hhi_pkg::HALF_W-1:0]);
    assign rsum = {1'b0, acc_reg} + ((ACC_W+1)'(1) << (hhi_pkg::FRAC_W - 1));
    assign prod = hhi_pkg::qsat(rsum[ACC_W:hhi_pkg::FRAC_W], mneg_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_acc && req.req_type == hhi_pkg::REQ_QUERY) state_next = S_SCAN;
            S_SCAN: state_next = (idx_reg >= filled_reg) ? S_IDLE : S_SCMP;
            S_SCMP:
            begin
                if (t_reg < tm_rd_reg)
                    state_next = (idx_reg == '0) ? S_IDLE : S_F0;
                else
                    state_next = S_SCAN;
            end
            S_F0:   state_next = S_F1;
            S_F1:   state_next = S_F2;
            S_F2:   state_next = S_CHK;
            S_CHK:  state_next = (tn_reg == tb_reg) ? S_IDLE : S_DIV;
            S_DIV:  if (div_cnt_reg == DCNT_W'(DVD_W - 1)) state_next = S_DFIN;
            S_DFIN: state_next = S_PREP;
            S_PREP: state_next = S_MLD;
            S_MLD:  state_next = S_MPP;
            S_MPP:  if (mk_reg == 2'd3) state_next = S_MFIN;
            S_MFIN: state_next = (step_reg == hhi_pkg::MS_OUT) ? S_IDLE : S_MLD;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            filled_reg    <= '0;
            for (int d = 0; d < hhi_pkg::NUM_DELAYS; d++)
                hint_reg[d] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Result handoff
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (out_load)
                done_reg <= 1'b0;
            else if (req_acc && req.req_type != hhi_pkg::REQ_QUERY)
                done_reg <= 1'b1;
            else if (state_reg != S_IDLE && state_next == S_IDLE)
                done_reg <= 1'b1;

            // Fill count
            if (wr_en && {1'b0, req.entry_index} >= filled_reg)
                filled_reg <= {1'b0, req.entry_index} + hhi_pkg::CNT_W'(1);

            // Search hints
            if (req_acc && req.req_type == hhi_pkg::REQ_CLEAR)
            begin
                for (int d = 0; d < hhi_pkg::NUM_DELAYS; d++)
                    hint_reg[d] <= '0;
            end
            else if (state_reg == S_SCMP && t_reg < tm_rd_reg)
            begin
                hint_reg[dly_reg] <= (idx_reg >= hhi_pkg::CNT_W'(2))
                    ? hhi_pkg::IDX_W'(idx_reg - hhi_pkg::CNT_W'(2)) : '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_val_reg    <= res_val_reg;
            out_status_reg <= res_status_reg;
            out_upper_reg  <= res_upper_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    t_reg          <= req.sample_time;
                    var_reg        <= req.var_index;
                    dly_reg        <= req.delay_index;
                    idx_reg        <= {1'b0, hint_reg[req.delay_index]};
                    res_val_reg    <= '0;
                    res_status_reg <= hhi_pkg::ST_OK;
                    res_upper_reg  <= '0;
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= filled_reg)
                    res_status_reg <= hhi_pkg::ST_NO_LATER;
            end
            S_SCMP:
            begin
                if (t_reg < tm_rd_reg)
                begin
                    tn_reg        <= tm_rd_reg;
                    res_upper_reg <= idx_reg[hhi_pkg::IDX_W-1:0];
                    if (idx_reg == '0)
                        res_status_reg <= hhi_pkg::ST_NO_PRED;
                end
                else
                    idx_reg <= idx_reg + hhi_pkg::CNT_W'(1);
            end
            S_F0: ;
            S_F1:
            begin
                tb_reg <= tm_rd_reg;
                xb_reg <= val_rd_reg;
                db_reg <= slp_rd_reg;
            end
            S_F2:
            begin
                xn_reg <= val_rd_reg;
                dn_reg <= slp_rd_reg;
            end
            S_CHK:
            begin
                if (tn_reg == tb_reg)
                begin
                    res_status_reg <= hhi_pkg::ST_ZERO_SPN;
                    res_val_reg    <= xb_reg;
                end
                h_reg       <= hhi_pkg::sat_sub(tn_reg, tb_reg);
                div_dvd_reg <= {hhi_pkg::mag(hhi_pkg::sat_sub(t_reg, tb_reg)),
                                hhi_pkg::FRAC_W'(0)};
                div_den_reg <= hhi_pkg::mag(hhi_pkg::sat_sub(tn_reg, tb_reg));
                div_neg_reg <= hhi_pkg::sat_sub(t_reg, tb_reg) < 0
                            != hhi_pkg::sat_sub(tn_reg, tb_reg) < 0;
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_ovf_reg <= 1'b0;
                div_cnt_reg <= '0;
            end
            // One quotient bit per cycle
            S_DIV:
            begin
                div_rem_reg <= rem_ge ? rem_sh - {1'b0, div_den_reg} : rem_sh;
                div_q_reg   <= {div_q_reg[hhi_pkg::Q_W-2:0], rem_ge};
                div_ovf_reg <= div_ovf_reg | div_q_reg[hhi_pkg::Q_W-1];
                div_dvd_reg <= {div_dvd_reg[DVD_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
            end
            S_DFIN: th_reg <= th_new;
            S_PREP:
            begin
                thm1_reg  <= hhi_pkg::sat_sub(th_reg, hhi_pkg::Q_ONE);
                oneth_reg <= hhi_pkg::sat_sub(hhi_pkg::Q_ONE, th_reg);
                b1a_reg   <= hhi_pkg::sat_sub(hhi_pkg::Q_ONE,
                                              hhi_pkg::sat_add(th_reg, th_reg));
                dx_reg    <= hhi_pkg::sat_sub(xn_reg, xb_reg);
                step_reg  <= hhi_pkg::MS_LIN_B;
            end
            S_MLD:
            begin
                ua_reg   <= hhi_pkg::mag(opa);
                ub_reg   <= hhi_pkg::mag(opb);
                mneg_reg <= (opa < 0) != (opb < 0);
                acc_reg  <= '0;
                mk_reg   <= '0;
            end
            // Four partial products, shifted by 0, 24 or 48 bits
            S_MPP:
            begin
                unique case ({mk_reg[1], mk_reg[0]})
                    2'b00:         acc_reg <= acc_reg + ACC_W'(pp);
                    2'b01, 2'b10:  acc_reg <= acc_reg + (ACC_W'(pp) << hhi_pkg::HALF_W);
                    2'b11:         acc_reg <= acc_reg + (ACC_W'(pp) << hhi_pkg::Q_W);
                    default:       acc_reg <= acc_reg;
                endcase
                mk_reg <= mk_reg + 2'd1;
            end
            // Accumulate the rounded product into the Hermite terms
            S_MFIN:
            begin
                unique case (step_reg)
                    hhi_pkg::MS_LIN_B: lin_reg <= prod;
                    hhi_pkg::MS_LIN_N: lin_reg <= hhi_pkg::sat_add(lin_reg, prod);
                    hhi_pkg::MS_B1:    inn_reg <= prod;
                    hhi_pkg::MS_HB:    tmp_reg <= prod;
                    hhi_pkg::MS_B2:    inn_reg <= hhi_pkg::sat_add(inn_reg, prod);
                    hhi_pkg::MS_HN:    tmp_reg <= prod;
                    hhi_pkg::MS_B3:    inn_reg <= hhi_pkg::sat_add(inn_reg, prod);
                    hhi_pkg::MS_TT:    tmp_reg <= prod;
                    hhi_pkg::MS_OUT:   res_val_reg <= hhi_pkg::sat_add(lin_reg, prod);
                    default:           tmp_reg <= tmp_reg;
                endcase
                step_reg <= hhi_pkg::mstep_t'(step_reg + 4'd1);
            end
            default: ;
        endcase
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives write, clear and query items into the Hermite history interpolator
// and checks every response against a Q24.24 prediction of the history table.
// ----------------------------------------------------------------------------
typedef struct {
    hhi_pkg::req_t                   kind;
    logic [hhi_pkg::IDX_W-1:0]       ent;
    logic [hhi_pkg::VAR_W-1:0]       vsel;
    logic [hhi_pkg::DLY_W-1:0]       dly;
    logic signed [hhi_pkg::Q_W-1:0]  t;
    logic signed [hhi_pkg::Q_W-1:0]  v;
    logic signed [hhi_pkg::Q_W-1:0]  s;
} hist_req_t;

typedef struct {
    logic signed [hhi_pkg::Q_W-1:0]  value;
    hhi_pkg::status_t                st;
    logic [hhi_pkg::IDX_W-1:0]       upper;
} hist_rsp_t;

class hermite_predictor;
    localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint QMIN = -64'sh7FFF_FFFF_FFFF - 1;
    localparam longint QONE = 64'sd1 << hhi_pkg::FRAC_W;

    longint    times [hhi_pkg::HIST_DEPTH];
    longint    vals [hhi_pkg::HIST_DEPTH*hhi_pkg::NUM_VARS];
    longint    slopes [hhi_pkg::HIST_DEPTH*hhi_pkg::NUM_VARS];
    bit        time_seen [hhi_pkg::HIST_DEPTH];
    bit        var_seen [hhi_pkg::HIST_DEPTH*hhi_pkg::NUM_VARS];
    int        hints [hhi_pkg::NUM_DELAYS];
    int        filled;
    hist_rsp_t pending_results [$];
    int        errors;

    function new();
        foreach (hints[i]) hints[i] = 0;
        foreach (time_seen[i]) time_seen[i] = 0;
        foreach (var_seen[i]) var_seen[i] = 0;
        filled = 0;
        errors = 0;
    endfunction

    function longint sat(longint a);
        if (a > QMAX) return QMAX;
        if (a < QMIN) return QMIN;
        return a;
    endfunction

    function longint apply_sign(logic [48:0] m, bit neg);
        if (neg) begin
            if (m > 49'(64'sd1 << 47)) return QMIN;
            return -longint'(m);
        end
        if (m > 49'(QMAX)) return QMAX;
        return longint'(m);
    endfunction

    function logic [47:0] magnitude(longint a);
        return (a < 0) ? 48'(-a) : 48'(a);
    endfunction

    // Q24.24 product, rounded half away from zero
    function longint qmul(longint a, longint b);
        logic [95:0] p;
        logic [96:0] pr;
        logic [48:0] m;
        p = {48'b0, magnitude(a)} * {48'b0, magnitude(b)};
        pr = {1'b0, p} + 97'(1 << 23);
        if (pr[96:71] != 0) m = 49'(1) << 48;
        else m = {2'b0, pr[70:24]};
        return apply_sign(m, (a < 0) != (b < 0));
    endfunction

    // Q24.24 quotient truncated toward zero
    function longint qdiv(longint n, longint d);
        logic [47:0] un, ud;
        logic [71:0] q;
        bit neg;
        un = magnitude(n);
        ud = magnitude(d);
        neg = (n < 0) != (d < 0);
        if ((un / ud) >= 48'(1 << 24)) return neg ? QMIN : QMAX;
        q = {un, 24'b0} / {24'b0, ud};
        return apply_sign(q[48:0], neg);
    endfunction

    // True when a query touches only entries that hold data
    function bit query_is_safe(logic signed [hhi_pkg::Q_W-1:0] t, int vsel, int dly);
        int i;
        i = hints[dly];
        for (; i < filled; i++) begin
            if (!time_seen[i]) return 0;
            if (longint'(t) < times[i]) break;
        end
        if (i >= filled || i == 0) return 1;
        return time_seen[i-1] && var_seen[(i-1)*hhi_pkg::NUM_VARS+vsel]
            && var_seen[i*hhi_pkg::NUM_VARS+vsel];
    endfunction

    // Update the table for one accepted item and queue its response
    function void note_request(hist_req_t r);
        hist_rsp_t e;
        int i, lo, a;
        bit hit;
        longint tq, tb, tn, h, xb, xn, db, dn, th, thm1, lin, b1, b2, b3, inner;
        e.value = '0;
        e.st = hhi_pkg::ST_OK;
        e.upper = '0;
        tq = longint'(r.t);
        case (r.kind)
            hhi_pkg::REQ_WRITE:
            begin
                a = int'(r.ent)*hhi_pkg::NUM_VARS + int'(r.vsel);
                times[r.ent] = tq;
                time_seen[r.ent] = 1;
                vals[a] = longint'(r.v);
                slopes[a] = longint'(r.s);
                var_seen[a] = 1;
                if (int'(r.ent) + 1 > filled) filled = int'(r.ent) + 1;
            end
            hhi_pkg::REQ_CLEAR:
                foreach (hints[k]) hints[k] = 0;
            hhi_pkg::REQ_QUERY:
            begin
                hit = 0;
                for (i = hints[r.dly]; i < filled; i++) begin
                    if (tq < times[i]) begin
                        hit = 1;
                        break;
                    end
                end
                if (!hit) e.st = hhi_pkg::ST_NO_LATER;
                else begin
                    hints[r.dly] = (i >= 2) ? i - 2 : 0;
                    e.upper = hhi_pkg::IDX_W'(i);
                    if (i == 0) e.st = hhi_pkg::ST_NO_PRED;
                    else begin
                        lo = i - 1;
                        tb = times[lo];
                        tn = times[i];
                        h = sat(tn - tb);
                        xb = vals[lo*hhi_pkg::NUM_VARS+r.vsel];
                        xn = vals[i*hhi_pkg::NUM_VARS+r.vsel];
                        db = slopes[lo*hhi_pkg::NUM_VARS+r.vsel];
                        dn = slopes[i*hhi_pkg::NUM_VARS+r.vsel];
                        if (tn == tb) begin
                            e.st = hhi_pkg::ST_ZERO_SPN;
                            e.value = hhi_pkg::Q_W'(xb);
                        end else begin
                            th = qdiv(sat(tq - tb), h);
                            thm1 = sat(th - QONE);
                            lin = sat(qmul(sat(QONE - th), xb) + qmul(th, xn));
                            b1 = qmul(sat(QONE - sat(th + th)), sat(xn - xb));
                            b2 = qmul(qmul(thm1, h), db);
                            b3 = qmul(qmul(th, h), dn);
                            inner = sat(sat(b1 + b2) + b3);
                            e.value = hhi_pkg::Q_W'(sat(lin + qmul(qmul(th, thm1), inner)));
                        end
                    end
                end
            end
            default: ;
        endcase
        pending_results.push_back(e);
    endfunction

    function void check_response(hist_rsp_t got);
        hist_rsp_t e;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected response value=%h status=%0d upper=%0d",
                     $time, got.value, got.st, got.upper);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (got.value !== e.value) begin
            $display("%0t: interp_value expected %h actual %h", $time, e.value, got.value);
            errors++;
        end
        if (got.st !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
            errors++;
        end
        if (got.upper !== e.upper) begin
            $display("%0t: upper_index expected %0d actual %0d", $time, e.upper, got.upper);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DENSE_MAX   = 48;

    logic clk;
    logic rst_n;
    int   snd_idle_pct;
    int   rcv_idle_pct;
    int   hold_left;
    int   cycles;

    hermite_predictor model;

    hhi_req_if req ();
    hhi_rsp_if rsp ();

    hermite_history_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: random stalls plus an optional long hold-off
    initial
    begin
        rsp.ready = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp.ready = 0;
                hold_left--;
            end else
                rsp.ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        hist_rsp_t got;
        if (rst_n && rsp.valid && rsp.ready) begin
            got.value = rsp.interp_value;
            got.st = hhi_pkg::status_t'(rsp.status);
            got.upper = rsp.upper_index;
            model.check_response(got);
        end
    end

    task automatic send_item(hist_req_t it);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            req.valid = 0;
            @(negedge clk);
        end
        req.req_type = it.kind;
        req.entry_index = it.ent;
        req.var_index = it.vsel;
        req.delay_index = it.dly;
        req.sample_time = it.t;
        req.sample_value = it.v;
        req.sample_slope = it.s;
        req.valid = 1;
        do @(posedge clk); while (!req.ready);
        model.note_request(it);
    endtask

    task automatic drain();
        @(negedge clk);
        req.valid = 0;
        while (model.pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic hist_req_t make_req(hhi_pkg::req_t k, int ent, int vsel, int dly,
                                           longint t, longint v, longint s);
        hist_req_t it;
        it.kind = k;
        it.ent = hhi_pkg::IDX_W'(ent);
        it.vsel = hhi_pkg::VAR_W'(vsel);
        it.dly = hhi_pkg::DLY_W'(dly);
        it.t = hhi_pkg::Q_W'(t);
        it.v = hhi_pkg::Q_W'(v);
        it.s = hhi_pkg::Q_W'(s);
        return it;
    endfunction

    function automatic longint rand_q();
        return longint'({$urandom, $urandom} << 16) >>> 16;
    endfunction

    function automatic longint rand_sample();
        if ($urandom_range(3) == 0) return rand_q();
        return longint'($signed($urandom)) >>> $urandom_range(31);
    endfunction

    // Mostly ordered history with random content, some noise
    task automatic random_phase(int n);
        int count, pick, ent, vsel, dly, base;
        longint t;
        count = 0;
        while (count < n) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                if (model.filled < DENSE_MAX && $urandom_range(2) != 0) ent = model.filled;
                else ent = $urandom_range(model.filled - 1);
                t = longint'(ent) << hhi_pkg::FRAC_W;
                t += $urandom_range((1 << 23) - 1);
                pick = $urandom_range(99);
                if (pick < 8 && ent > 0 && model.time_seen[ent-1]) t = model.times[ent-1];
                else if (pick < 12) t = rand_q();
                if ($urandom_range(2) == 0) begin
                    for (int k = 0; k < hhi_pkg::NUM_VARS; k++)
                        send_item(make_req(hhi_pkg::REQ_WRITE, ent, k, 0, t,
                                           rand_sample(), rand_sample()));
                    count += hhi_pkg::NUM_VARS;
                end else begin
                    send_item(make_req(hhi_pkg::REQ_WRITE, ent,
                                       $urandom_range(hhi_pkg::NUM_VARS-1), 0, t,
                                       rand_sample(), rand_sample()));
                    count++;
                end
            end else if (pick < 20) begin
                send_item(make_req(hhi_pkg::REQ_CLEAR, $urandom, $urandom, $urandom,
                                   rand_q(), rand_q(), rand_q()));
                count++;
            end else if (pick < 23) begin
                send_item(make_req(hhi_pkg::REQ_NOP, $urandom, $urandom, $urandom,
                                   rand_q(), rand_q(), rand_q()));
                count++;
            end else begin
                vsel = $urandom_range(hhi_pkg::NUM_VARS-1);
                dly = $urandom_range(hhi_pkg::NUM_DELAYS-1);
                pick = $urandom_range(99);
                base = $urandom_range(model.filled);
                if (pick < 15) t = rand_q();
                else if (pick < 25 && model.time_seen[base % model.filled])
                    t = model.times[base % model.filled];
                else t = (longint'(base) << hhi_pkg::FRAC_W) + $urandom_range((1 << 24) - 1);
                if (model.query_is_safe(hhi_pkg::Q_W'(t), vsel, dly)) begin
                    send_item(make_req(hhi_pkg::REQ_QUERY, $urandom, vsel, dly, t,
                                       rand_q(), rand_q()));
                    count++;
                end
            end
        end
    endtask

    initial
    begin
        longint one;
        one = 64'sd1 << hhi_pkg::FRAC_W;
        model = new();
        cycles = 0;
        hold_left = 0;
        snd_idle_pct = 17;
        rcv_idle_pct = 59;
        req.valid = 0;
        req.req_type = hhi_pkg::REQ_NOP;
        req.entry_index = '0;
        req.var_index = '0;
        req.delay_index = '0;
        req.sample_time = '0;
        req.sample_value = '0;
        req.sample_slope = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: small table with extremes, then each status
        send_item(make_req(hhi_pkg::REQ_WRITE, 0, 0, 0, 0, one, one));
        send_item(make_req(hhi_pkg::REQ_WRITE, 1, 0, 0, one, hhi_pkg::Q_MAX,
                           hhi_pkg::Q_MIN));
        send_item(make_req(hhi_pkg::REQ_WRITE, 2, 0, 0, 2*one, hhi_pkg::Q_MIN,
                           hhi_pkg::Q_MAX));
        send_item(make_req(hhi_pkg::REQ_WRITE, 3, 0, 0, 2*one, -3*one, one/2));
        send_item(make_req(hhi_pkg::REQ_WRITE, 4, 0, 0, 4*one, 5*one, -one));
        send_item(make_req(hhi_pkg::REQ_WRITE, 5, 0, 0, 5*one, -one, 2*one));
        send_item(make_req(hhi_pkg::REQ_WRITE, 4, 7, 0, 4*one, hhi_pkg::Q_MIN, -one));
        send_item(make_req(hhi_pkg::REQ_WRITE, 5, 7, 0, 5*one, hhi_pkg::Q_MAX, one));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, -one, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, one/2, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, 3*one/2, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, 9*one/2, 0, 0));
        // hint now sits past entry 2, so equal times at 2 and 3 give zero span
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, 3*one/2, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 1, hhi_pkg::Q_MAX, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 7, hhi_pkg::Q_MIN, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 7, 7, 9*one/2, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 2, 5*one - 1, 0, 0));
        send_item(make_req(hhi_pkg::REQ_NOP, 4095, 7, 7, -1, -1, -1));
        send_item(make_req(hhi_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        send_item(make_req(hhi_pkg::REQ_QUERY, 0, 0, 0, 3*one/2, 0, 0));
        for (int k = 0; k < hhi_pkg::NUM_VARS; k++)
            send_item(make_req(hhi_pkg::REQ_WRITE, 6, k, 0, 6*one,
                               rand_sample(), rand_sample()));
        drain();

        random_phase(150);
        drain();

        snd_idle_pct = 59;
        rcv_idle_pct = 17;
        random_phase(150);
        drain();

        // No idling; a long receiver hold-off backs the block up
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_left = 600;
        random_phase(150);

        // Top entry, all index bits set
        send_item(make_req(hhi_pkg::REQ_WRITE, hhi_pkg::HIST_DEPTH-1, hhi_pkg::NUM_VARS-1, 0,
                           hhi_pkg::Q_MAX, rand_q(), rand_q()));
        drain();
        repeat (300) @(posedge clk);
        if (model.errors == 0 && model.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
